// ----- design/germ_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// germ_pkg
// types, event codes and defaults shared by the grave/escape remapper
// ----------------------------------------------------------------------------
package germ_pkg;

  // event types
  localparam logic [15:0] EVT_SYN = 16'd0;
  localparam logic [15:0] EVT_KEY = 16'd1;
  localparam logic [15:0] EVT_MSC = 16'd4;

  // codes
  localparam logic [15:0] MSC_SCAN_CODE = 16'd4;
  localparam logic [15:0] SYNC_REPORT   = 16'd0;
  localparam logic [15:0] K_ESC         = 16'd1;
  localparam logic [15:0] K_GRAVE       = 16'd41;
  localparam logic [15:0] K_LSHIFT      = 16'd42;
  localparam logic [15:0] K_RSHIFT      = 16'd54;
  localparam logic [15:0] K_LALT        = 16'd56;
  localparam logic [15:0] K_RALT        = 16'd100;

  // modifier flag bits
  localparam logic [2:0] FLAG_SHIFT = 3'h1;
  localparam logic [2:0] FLAG_LALT  = 3'h2;
  localparam logic [2:0] FLAG_RALT  = 3'h4;

  // remap modes
  localparam logic MODE_GRAVE = 1'b0;
  localparam logic MODE_ESC   = 1'b1;

  // depth of the queue between front and back
  localparam int CMD_DEPTH = 4;

  typedef struct packed {
    logic        [15:0] ev_type;
    logic        [15:0] ev_code;
    logic signed [31:0] ev_value;
  } in_ev_t;

  typedef struct packed {
    logic        [15:0] out_type;
    logic        [15:0] out_code;
    logic signed [31:0] out_value;
    logic               last_of_run;
  } out_ev_t;

  // one classified item: optional key release + sync ahead of the event
  typedef struct packed {
    logic        has_pre;
    logic [15:0] pre_code;
    in_ev_t      ev;
  } cmd_t;

endpackage

// ----- design/germ_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// germ_front
// accepts events, tracks modifiers and classifies each event into a command
// ----------------------------------------------------------------------------
module germ_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_data,
  input  logic              accept,
  input  germ_pkg::in_ev_t  ev_in,
  output logic              cmd_push,
  output germ_pkg::cmd_t    cmd
);

  logic       mode_r, mode_nxt;
  logic [2:0] flags_r, flags_nxt;
  logic [2:0] bit_sel;
  logic       is_key, is_scan, has_alt, has_shift;
  logic [15:0] code;

  assign is_key  = (ev_in.ev_type == germ_pkg::EVT_KEY);
  assign is_scan = (ev_in.ev_type == germ_pkg::EVT_MSC) &&
                   (ev_in.ev_code == germ_pkg::MSC_SCAN_CODE);
  assign code    = ev_in.ev_code;

  always_comb begin
    if ((code == germ_pkg::K_LSHIFT) || (code == germ_pkg::K_RSHIFT)) begin
      bit_sel = germ_pkg::FLAG_SHIFT;
    end else if (code == germ_pkg::K_LALT) begin
      bit_sel = germ_pkg::FLAG_LALT;
    end else if (code == germ_pkg::K_RALT) begin
      bit_sel = germ_pkg::FLAG_RALT;
    end else begin
      bit_sel = 3'b000;
    end
  end

  always_comb begin
    flags_nxt = flags_r;
    if (is_key) begin
      if (ev_in.ev_value != 32'sd0) begin
        flags_nxt = flags_r | bit_sel;
      end else begin
        flags_nxt = flags_r & ~bit_sel;
      end
    end
  end

  assign has_shift = |(flags_nxt & germ_pkg::FLAG_SHIFT);
  assign has_alt   = |(flags_nxt & (germ_pkg::FLAG_LALT | germ_pkg::FLAG_RALT));

  always_comb begin
    cmd          = '0;
    cmd.ev       = ev_in;
    cmd.has_pre  = 1'b0;
    cmd.pre_code = (|(flags_nxt & germ_pkg::FLAG_LALT)) ? germ_pkg::K_LALT
                                                         : germ_pkg::K_RALT;
    if (is_key) begin
      if (mode_r == germ_pkg::MODE_GRAVE) begin
        if (code == germ_pkg::K_GRAVE) begin
          if (has_shift) begin
            cmd.has_pre = 1'b0;
          end else if (has_alt) begin
            cmd.has_pre = 1'b1;
          end else begin
            cmd.ev.ev_code = germ_pkg::K_ESC;
            if (ev_in.ev_value == 32'sd0) begin
              cmd.has_pre  = 1'b1;
              cmd.pre_code = germ_pkg::K_GRAVE;
            end
          end
        end
      end else begin
        if (code == germ_pkg::K_ESC) begin
          if (has_shift) begin
            cmd.ev.ev_code = germ_pkg::K_GRAVE;
          end else if (has_alt) begin
            cmd.has_pre    = 1'b1;
            cmd.ev.ev_code = germ_pkg::K_GRAVE;
          end
        end
      end
    end
  end

  // scan events are dropped here
  assign cmd_push = accept && !is_scan;
  assign mode_nxt = cfg_we ? cfg_data : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= germ_pkg::MODE_GRAVE;
      flags_r <= 3'b000;
    end else begin
      mode_r <= mode_nxt;
      if (accept) begin
        flags_r <= flags_nxt;
      end
    end
  end

endmodule

// ----- design/germ_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// germ_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module germ_cmd_fifo #(
  parameter int DEPTH = germ_pkg::CMD_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  germ_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output germ_pkg::cmd_t rd_data,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  germ_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- design/germ_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// germ_back
// expands each command into one to three events into the output register
// ----------------------------------------------------------------------------
module germ_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fifo_empty,
  input  germ_pkg::cmd_t    fifo_data,
  output logic              fifo_rd,
  output logic              out_vld,
  output germ_pkg::out_ev_t out_ev,
  input  logic              out_take
);

  localparam logic [1:0] STEP_PRE  = 2'd0;
  localparam logic [1:0] STEP_SYNC = 2'd1;
  localparam logic [1:0] STEP_EVT  = 2'd2;

  germ_pkg::cmd_t    cmd_r, cmd_nxt;
  logic              cmd_vld_r, cmd_vld_nxt;
  logic [1:0]        step_r, step_nxt;
  germ_pkg::out_ev_t out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              emit, done;
  germ_pkg::out_ev_t ev_sel;

  // a slot opens when the output register is empty or being drained
  assign emit    = cmd_vld_r && (!out_vld_r || out_take);
  assign done    = emit && (step_r == STEP_EVT);
  assign fifo_rd = !fifo_empty && (!cmd_vld_r || done);

  always_comb begin
    case (step_r)
      STEP_PRE: begin
        ev_sel = '{out_type: germ_pkg::EVT_KEY, out_code: cmd_r.pre_code,
                   out_value: 32'sd0, last_of_run: 1'b0};
      end
      STEP_SYNC: begin
        ev_sel = '{out_type: germ_pkg::EVT_SYN, out_code: germ_pkg::SYNC_REPORT,
                   out_value: 32'sd0, last_of_run: 1'b0};
      end
      STEP_EVT: begin
        ev_sel = '{out_type: cmd_r.ev.ev_type, out_code: cmd_r.ev.ev_code,
                   out_value: cmd_r.ev.ev_value, last_of_run: 1'b1};
      end
      default: begin
        ev_sel = '{out_type: cmd_r.ev.ev_type, out_code: cmd_r.ev.ev_code,
                   out_value: cmd_r.ev.ev_value, last_of_run: 1'b1};
      end
    endcase
  end

  always_comb begin
    cmd_nxt     = cmd_r;
    cmd_vld_nxt = cmd_vld_r;
    step_nxt    = step_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_take;
    if (emit) begin
      out_nxt     = ev_sel;
      out_vld_nxt = 1'b1;
      case (step_r)
        STEP_PRE:  step_nxt = STEP_SYNC;
        STEP_SYNC: step_nxt = STEP_EVT;
        default:   cmd_vld_nxt = 1'b0;
      endcase
    end
    if (fifo_rd) begin
      cmd_nxt     = fifo_data;
      cmd_vld_nxt = 1'b1;
      step_nxt    = fifo_data.has_pre ? STEP_PRE : STEP_EVT;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
      step_r    <= STEP_EVT;
      out_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
      step_r    <= step_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign out_ev  = out_r;

endmodule

// ----- design/grave_escape_key_remapper.sv -----
`timescale 1ns / 1ps
// path: an accepted event passes the command queue, command register and output register
// throughput: one result per cycle while pop keeps draining; an event gives one result,
//   or three with a key release and sync ahead, all paced by the single output register
// reset: synchronous active-low rst_n empties both queues, clears modifiers and
//   sets remap_mode to 0 (physical key is grave)
// ----------------------------------------------------------------------------
// grave_escape_key_remapper
// input event filter that swaps the grave and escape keys around modifiers
// ----------------------------------------------------------------------------
module grave_escape_key_remapper #(
  parameter int CMD_DEPTH = germ_pkg::CMD_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration: remap_mode
  input  logic              cfg_we,
  input  logic              cfg_data,
  // input queue side
  input  logic              push,
  output logic              full,
  input  germ_pkg::in_ev_t  in_data,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output germ_pkg::out_ev_t out_data
);

  logic              accept;
  logic              cmd_push;
  germ_pkg::cmd_t    cmd_wr;
  germ_pkg::cmd_t    cmd_rd;
  logic              cmd_empty;
  logic              cmd_full;
  logic              cmd_pop;
  logic              out_vld;

  // input transfer: full only reflects the command queue
  assign accept = push && !cmd_full;
  assign full   = cmd_full;

  // front: modifier tracking, scan drop, remap decision
  germ_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .ev_in    (in_data),
    .cmd_push (cmd_push),
    .cmd      (cmd_wr)
  );

  // decoupling queue, lets the front keep accepting while the back expands
  germ_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  // back: one output event per cycle from the current command while the output is drained
  germ_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (cmd_empty),
    .fifo_data  (cmd_rd),
    .fifo_rd    (cmd_pop),
    .out_vld    (out_vld),
    .out_ev     (out_data),
    .out_take   (pop)
  );

  // result transfer happens on pop while not empty
  assign empty = !out_vld;

endmodule

// ----- design/germ_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// germ_checker
// port-level checks on the remapper, attached by bind
// ----------------------------------------------------------------------------
module germ_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input germ_pkg::out_ev_t out_data
);

  // reset drains the result side
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  // reset drains the input side
  a_rst_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  // inserted events are key releases or syncs
  a_prefix_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.last_of_run) |->
      (out_data.out_value == 32'sd0 &&
       (out_data.out_type == germ_pkg::EVT_KEY ||
        out_data.out_type == germ_pkg::EVT_SYN)))
    else $error("inserted event is not a release or sync");

  // scan events never reach the output
  a_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_data.out_type == germ_pkg::EVT_MSC &&
                 out_data.out_code == germ_pkg::MSC_SCAN_CODE))
    else $error("scan event passed through");

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed");

endmodule

bind grave_escape_key_remapper germ_checker u_germ_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
